### rtl/csda_pkg.sv
`timescale 1ns / 1ps

package csda_pkg;

  // Display geometry
  localparam int NUM_DIGITS  = 4;
  localparam int DIG_W       = $clog2(NUM_DIGITS);
  localparam int POINT_DIGIT = 2;
  localparam int QUEUE_DEPTH = 2;

  // Request codes
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_BUTTON = 2'd1;
  localparam logic [1:0] REQ_SAMPLE = 2'd2;

  // Tone codes
  localparam logic [1:0] TONE_OFF   = 2'd0;
  localparam logic [1:0] TONE_TIMER = 2'd1;
  localparam logic [1:0] TONE_AIR   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_AIR_THRESHOLD  = 2'd0;
  localparam logic [1:0] CFG_RELOAD_SECONDS = 2'd1;
  localparam logic [1:0] CFG_ALARM_LENGTH   = 2'd2;

  // Reset values
  localparam logic [9:0]  AIR_THRESHOLD_RST  = 10'd240;
  localparam logic [12:0] RELOAD_SECONDS_RST = 13'd3600;
  localparam logic [7:0]  ALARM_LENGTH_RST   = 8'd100;

  // Sensor conversion: ppm = (adc * 250 - 5120) / 1024
  localparam logic [17:0] ADC_GAIN   = 18'd250;
  localparam logic [17:0] ADC_OFFSET = 18'd5120;

  // Reciprocal of 60: exact for 13-bit values with a 19-bit shift
  localparam logic [13:0] RECIP_60 = 14'd8739;
  localparam int          SHIFT_60 = 19;

  typedef struct packed {
    logic [1:0] req_type;
    logic [9:0] sensor_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] segments;
    logic [3:0] digit_select;
    logic [1:0] tone;
    logic       last_digit;
  } out_item_t;

  // One display scan waiting for the back end
  typedef struct packed {
    logic [NUM_DIGITS-1:0][3:0] digits;
    logic                       point;
    logic [1:0]                 tone;
  } scan_t;

  // Quotient by ten for values below 256 (reciprocal 205 / 2048)
  function automatic logic [4:0] div10(input logic [7:0] val);
    logic [15:0] prod;
    prod = 16'(val) * 16'd205;
    return prod[15:11];
  endfunction

  // Remainder by ten for values below 256
  function automatic logic [3:0] mod10(input logic [7:0] val);
    logic [7:0] quo;
    quo = 8'(div10(val));
    return 4'(val - 8'(quo * 8'd10));
  endfunction

  // Seven-segment patterns, bit 7 left for the decimal point
  function automatic logic [7:0] seg_of(input logic [3:0] dig);
    logic [7:0] seg;
    unique case (dig)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

### rtl/csda_front.sv
`timescale 1ns / 1ps

module csda_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  csda_pkg::in_item_t in_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [12:0]       cfg_data,
  output logic              push,
  output csda_pkg::scan_t   push_data,
  input  logic              queue_full
);
  import csda_pkg::*;

  logic [9:0]  air_threshold;
  logic [12:0] reload_seconds;
  logic [7:0]  alarm_length;
  logic        display_mode;
  logic [12:0] seconds_left;
  logic [7:0]  alarm_count;

  logic        accept;
  logic [17:0] scaled;
  logic [20:0] air_limit;
  logic        air;
  logic        secs_zero;
  logic [7:0]  count_armed;
  logic [1:0]  tone_now;
  logic [7:0]  ppm;

  // Stage 1: snapshot of a sample
  logic        p1_valid;
  logic        p1_mode;
  logic [12:0] p1_secs;
  logic [7:0]  p1_ppm;
  logic [1:0]  p1_tone;
  logic        p1_adv;

  // Stage 2: minutes and seconds split
  logic        p2_valid;
  logic        p2_mode;
  logic [7:0]  p2_mins;
  logic [5:0]  p2_secs;
  logic [7:0]  p2_ppm;
  logic [1:0]  p2_tone;
  logic        p2_free;

  logic [26:0] mins_prod;
  logic [7:0]  mins_calc;
  logic [12:0] secs_calc;

  logic [4:0]  tq;
  logic [4:0]  sq;
  logic [4:0]  pq;
  logic [13:0] hund_prod;

  assign cfg_ready = 1'b1;

  // Pipeline flow control
  assign push     = p2_valid && !queue_full;
  assign p2_free  = !p2_valid || push;
  assign p1_adv   = p1_valid && p2_free;
  assign in_stall = p1_valid && !p2_free;
  assign accept   = in_valid && !in_stall;

  // Classify the sample against the warning level and the alarm state
  always_comb begin
    scaled      = 18'(in_data.sensor_code) * ADC_GAIN;
    air_limit   = {1'b0, air_threshold, 10'b0} + 21'(ADC_OFFSET);
    air         = 21'(scaled) > air_limit;
    ppm         = (scaled >= ADC_OFFSET) ? 8'((scaled - ADC_OFFSET) >> 10) : 8'd0;
    secs_zero   = (seconds_left == 13'd0);
    count_armed = (secs_zero || air) ? alarm_length : alarm_count;
    if (count_armed == 8'd0) begin
      tone_now = TONE_OFF;
    end else if (secs_zero) begin
      tone_now = TONE_TIMER;
    end else if (air) begin
      tone_now = TONE_AIR;
    end else begin
      tone_now = TONE_OFF;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      air_threshold  <= AIR_THRESHOLD_RST;
      reload_seconds <= RELOAD_SECONDS_RST;
      alarm_length   <= ALARM_LENGTH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_AIR_THRESHOLD:  air_threshold  <= cfg_data[9:0];
        CFG_RELOAD_SECONDS: reload_seconds <= cfg_data;
        CFG_ALARM_LENGTH:   alarm_length   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Advance timer, mode and alarm state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode <= 1'b0;
      seconds_left <= RELOAD_SECONDS_RST;
      alarm_count  <= 8'd0;
    end else if (accept) begin
      unique case (in_data.req_type)
        REQ_TICK: begin
          if (secs_zero) begin
            alarm_count  <= alarm_length;
            seconds_left <= reload_seconds;
          end else begin
            seconds_left <= seconds_left - 13'd1;
          end
        end
        REQ_BUTTON: display_mode <= !display_mode;
        REQ_SAMPLE: begin
          alarm_count <= (count_armed == 8'd0) ? 8'd0 : count_armed - 8'd1;
        end
        default: ;
      endcase
    end
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (accept && in_data.req_type == REQ_SAMPLE) begin
      p1_valid <= 1'b1;
    end else if (p1_adv) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.req_type == REQ_SAMPLE) begin
      p1_mode <= display_mode;
      p1_secs <= seconds_left;
      p1_ppm  <= ppm;
      p1_tone <= tone_now;
    end
  end

  // Split seconds into minutes and seconds
  always_comb begin
    mins_prod = 27'(p1_secs) * 27'(RECIP_60);
    mins_calc = mins_prod[SHIFT_60 +: 8];
    secs_calc = p1_secs - 13'(mins_calc * 13'd60);
  end

  // Stage 2 register
  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (p2_free) begin
      p2_valid <= p1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_adv) begin
      p2_mode <= p1_mode;
      p2_mins <= mins_calc;
      p2_secs <= secs_calc[5:0];
      p2_ppm  <= p1_ppm;
      p2_tone <= p1_tone;
    end
  end

  // Take the shown value apart into decimal digits
  always_comb begin
    tq        = div10(p2_mins);
    sq        = div10({2'b0, p2_secs});
    pq        = div10(p2_ppm);
    hund_prod = 14'(p2_ppm) * 14'd41;
    push_data.tone  = p2_tone;
    push_data.point = !p2_mode;
    if (!p2_mode) begin
      push_data.digits[3] = (tq >= 5'd10) ? 4'(tq - 5'd10) : tq[3:0];
      push_data.digits[2] = mod10(p2_mins);
      push_data.digits[1] = sq[3:0];
      push_data.digits[0] = mod10({2'b0, p2_secs});
    end else begin
      push_data.digits[3] = 4'd0;
      push_data.digits[2] = {2'b0, hund_prod[13:12]};
      push_data.digits[1] = mod10({3'b0, pq});
      push_data.digits[0] = mod10(p2_ppm);
    end
  end

endmodule

### rtl/csda_queue.sv
`timescale 1ns / 1ps

module csda_queue #(
  parameter int DEPTH = csda_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  csda_pkg::scan_t push_data,
  output logic            full,
  input  logic            pop,
  output csda_pkg::scan_t head,
  output logic            empty
);
  import csda_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  scan_t          entries [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Store the incoming scan
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### rtl/csda_back.sv
`timescale 1ns / 1ps

module csda_back (
  input  logic                clk,
  input  logic                rst,
  input  csda_pkg::scan_t     head,
  input  logic                empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output csda_pkg::out_item_t out_data
);
  import csda_pkg::*;

  logic [DIG_W-1:0] idx;
  logic             load;
  logic             last;
  out_item_t        item_next;

  assign load = !empty && (!out_valid || !out_stall);
  assign last = (idx == DIG_W'(NUM_DIGITS - 1));
  assign pop  = load && last;

  // Build the request for the current digit
  always_comb begin
    item_next.segments = seg_of(head.digits[idx]);
    if (head.point && idx == DIG_W'(POINT_DIGIT)) begin
      item_next.segments[7] = 1'b1;
    end
    item_next.digit_select = 4'(1) << idx;
    item_next.tone         = head.tone;
    item_next.last_digit   = last;
  end

  // Step through the digits of the head scan
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx <= last ? '0 : idx + DIG_W'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the output request until taken
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= item_next;
    end
  end

endmodule

### rtl/countdown_sensor_display_alarm.sv
// A sensor sample passes stage 1, stage 2, the scan queue and the output register
// before its first digit request is valid. The back end sends one digit a cycle
// while out_stall is low; ticks and button presses give no request.
// A two-entry scan queue lets the front take new requests while digits drain.
// Reset (synchronous, active high) restores timer mode, 3600 s, silent alarm.
`timescale 1ns / 1ps

module countdown_sensor_display_alarm #(
  parameter int QUEUE_DEPTH = csda_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  csda_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output csda_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [12:0]         cfg_data
);
  import csda_pkg::*;

  logic  push;
  scan_t push_data;
  logic  queue_full;
  logic  pop;
  scan_t head;
  logic  empty;

  // Accept requests, keep state, compute digits
  csda_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_data  (push_data),
    .queue_full (queue_full)
  );

  // Buffer scans between the two halves
  csda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  // Send the four digits of each scan
  csda_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### tb/countdown_sensor_display_alarm_test.sv
`timescale 1ns / 1ps

module countdown_sensor_display_alarm_test;
  import csda_pkg::*;

  // Request code that the block must ignore
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Sensor conversion and clock arithmetic
  localparam int unsigned ADC_SCALE    = 250;
  localparam int unsigned ADC_BIAS     = 5120;
  localparam int unsigned PPM_DIV      = 1024;
  localparam int unsigned SECS_PER_MIN = 60;
  localparam logic [7:0]  POINT_BIT    = 8'h80;

  // Run control
  localparam int QUIET_LIMIT     = 5000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS     = 65;

  typedef enum logic {TIMER_VIEW, SENSOR_VIEW} view_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_AIR_THRESHOLD;
  logic [12:0] cfg_data = '0;

  // Predicted registers and state
  logic [9:0]  warn_level  = AIR_THRESHOLD_RST;
  logic [12:0] reload_secs = RELOAD_SECONDS_RST;
  logic [7:0]  alarm_len   = ALARM_LENGTH_RST;
  view_t       view        = TIMER_VIEW;
  logic [12:0] secs_left   = RELOAD_SECONDS_RST;
  logic [7:0]  alarm_cnt   = '0;

  logic [7:0] seg_pattern [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                   8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

  out_item_t pending_digits [$];

  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int hold_cycles     = 0;
  int quiet_cycles    = 0;
  int mismatches      = 0;
  int digits_checked  = 0;
  int scans_sent      = 0;
  int ticks_sent      = 0;
  int presses_sent    = 0;
  int ignored_sent    = 0;

  countdown_sensor_display_alarm DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Advance the predicted state by one request and queue the digits of a scan
  function automatic void apply_request(in_item_t item);
    int unsigned scaled;
    int unsigned ppm;
    int unsigned mins;
    int unsigned secs;
    logic        air;
    logic [1:0]  tone;
    logic [3:0]  shown [NUM_DIGITS];
    out_item_t   res;
    case (item.req_type)
      REQ_TICK: begin
        ticks_sent++;
        if (secs_left != 0) begin
          secs_left = secs_left - 13'd1;
        end else begin
          alarm_cnt = alarm_len;
          secs_left = reload_secs;
        end
      end
      REQ_BUTTON: begin
        presses_sent++;
        view = (view == TIMER_VIEW) ? SENSOR_VIEW : TIMER_VIEW;
      end
      REQ_SAMPLE: begin
        scans_sent++;
        scaled = item.sensor_code * ADC_SCALE;
        ppm = (scaled >= ADC_BIAS) ? (scaled - ADC_BIAS) / PPM_DIV : 0;
        air = scaled > warn_level * PPM_DIV + ADC_BIAS;
        if (view == TIMER_VIEW) begin
          mins = secs_left / SECS_PER_MIN;
          secs = secs_left % SECS_PER_MIN;
          shown[3] = 4'((mins / 10) % 10);
          shown[2] = 4'(mins % 10);
          shown[1] = 4'((secs / 10) % 10);
          shown[0] = 4'(secs % 10);
        end else begin
          shown[3] = 4'((ppm / 1000) % 10);
          shown[2] = 4'((ppm / 100) % 10);
          shown[1] = 4'((ppm / 10) % 10);
          shown[0] = 4'(ppm % 10);
        end
        // Arm on expiry or bad air, then sound and drain the counter
        if (secs_left == 0 || air) alarm_cnt = alarm_len;
        tone = TONE_OFF;
        if (alarm_cnt != 0) begin
          if (secs_left == 0) tone = TONE_TIMER;
          else if (air) tone = TONE_AIR;
          alarm_cnt = alarm_cnt - 8'd1;
        end
        for (int i = 0; i < NUM_DIGITS; i++) begin
          res.segments = seg_pattern[shown[i]];
          if (view == TIMER_VIEW && i == POINT_DIGIT) res.segments |= POINT_BIT;
          res.digit_select = 4'(1 << i);
          res.tone = tone;
          res.last_digit = (i == NUM_DIGITS - 1);
          pending_digits.push_back(res);
        end
      end
      default: ignored_sent++;
    endcase
  endfunction

  // Offer one request and hold it until accepted; valid stays high on return
  task automatic send_request(input logic [1:0] req, input logic [9:0] adc);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {req, adc};
    do @(posedge clk); while (in_stall);
    apply_request(in_data);
  endtask

  // Drop valid and wait until every scan has drained and the front is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [12:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_AIR_THRESHOLD:  warn_level = value[9:0];
      CFG_RELOAD_SECONDS: reload_secs = value;
      CFG_ALARM_LENGTH:   alarm_len = value[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Compare each accepted digit request with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_digits.size() == 0) begin
        mismatches++;
        $display("%0t ns: digit request expected none, got %h", $time, out_data);
      end else begin
        want = pending_digits.pop_front();
        digits_checked++;
        check_field("segments", want.segments, out_data.segments);
        check_field("digit_select", 8'(want.digit_select), 8'(out_data.digit_select));
        check_field("tone", 8'(want.tone), 8'(out_data.tone));
        check_field("last_digit", 8'(want.last_digit), 8'(out_data.last_digit));
      end
    end
  end

  // Stall the output at random, or hold it off for a counted stretch
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // End the run when no handshake completes for too long
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns: no handshake for %0d cycles", $time, quiet_cycles);
        $display("countdown_sensor_display_alarm_test: done, errors");
        $finish;
      end
    end
  end

  // Reset values: timer view, air threshold edges, ignored fields and codes
  task automatic test_power_on_display();
    sender_idle_pct = 0;
    stall_pct = 0;
    send_request(REQ_SAMPLE, 10'd0);
    send_request(REQ_SAMPLE, 10'd1003);
    send_request(REQ_SAMPLE, 10'd1004);
    send_request(REQ_SAMPLE, 10'd1023);
    send_request(REQ_TICK, 10'h3FF);
    send_request(REQ_UNUSED, 10'h3FF);
    send_request(REQ_SAMPLE, 10'h2AA);
    send_request(REQ_BUTTON, 10'h155);
    send_request(REQ_SAMPLE, 10'd0);
    send_request(REQ_SAMPLE, 10'd20);
    send_request(REQ_SAMPLE, 10'd21);
    send_request(REQ_SAMPLE, 10'h155);
    send_request(REQ_SAMPLE, 10'd1023);
    send_request(REQ_UNUSED, 10'd0);
    send_request(REQ_BUTTON, 10'd0);
    send_request(REQ_SAMPLE, 10'd512);
    settle();
  endtask

  // Warning level at both ends of its range
  task automatic test_register_extremes();
    write_register(CFG_AIR_THRESHOLD, 13'd0);
    send_request(REQ_BUTTON, 10'd0);
    send_request(REQ_SAMPLE, 10'd20);
    send_request(REQ_SAMPLE, 10'd21);
    send_request(REQ_SAMPLE, 10'd1023);
    settle();
    write_register(CFG_AIR_THRESHOLD, 13'd1023);
    send_request(REQ_SAMPLE, 10'd1023);
    send_request(REQ_BUTTON, 10'd0);
    send_request(REQ_SAMPLE, 10'd1023);
    settle();
  endtask

  // Alarm counter: arming on bad air, zero alarm length, short alarm running out
  task automatic test_alarm_arming();
    write_register(CFG_AIR_THRESHOLD, 13'd240);
    write_register(CFG_ALARM_LENGTH, 13'd255);
    send_request(REQ_SAMPLE, 10'd1023);
    send_request(REQ_SAMPLE, 10'd0);
    settle();
    write_register(CFG_ALARM_LENGTH, 13'd0);
    send_request(REQ_SAMPLE, 10'd1023);
    send_request(REQ_SAMPLE, 10'd0);
    settle();
    write_register(CFG_ALARM_LENGTH, 13'd2);
    send_request(REQ_SAMPLE, 10'd1023);
    send_request(REQ_SAMPLE, 10'd0);
    send_request(REQ_SAMPLE, 10'd0);
    send_request(REQ_SAMPLE, 10'd0);
    settle();
  endtask

  // Mixed traffic under four idling mixes, new settings between them
  task automatic test_random_traffic();
    int idle_mix [4] = '{0, 81, 0, 35};
    int stall_mix [4] = '{0, 0, 81, 35};
    int sent;
    int roll;
    int unsigned edge_adc;
    for (int p = 0; p < 4; p++) begin
      write_register(CFG_AIR_THRESHOLD, (p == 0) ? 13'd0 : (p == 3) ? 13'd1000 :
                     13'(($urandom_range(3) == 0) ? $urandom_range(1023)
                                                   : $urandom_range(120, 244)));
      write_register(CFG_RELOAD_SECONDS, (p == 0) ? 13'd1 : 13'($urandom_range(1, 12)));
      write_register(CFG_ALARM_LENGTH, (p == 0) ? 13'd1 : (p == 3) ? 13'd255 :
                     13'($urandom_range(1, 255)));
      sender_idle_pct = idle_mix[p];
      stall_pct = stall_mix[p];
      // Back up the output while requests keep coming
      if (p == 0) hold_cycles = HOLD_OFF_CYCLES;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        roll = $urandom_range(99);
        if (roll < 45) begin
          if ($urandom_range(4) == 0) begin
            edge_adc = (warn_level * PPM_DIV + ADC_BIAS) / ADC_SCALE + $urandom_range(2);
            if (edge_adc > 1024) edge_adc = 1024;
            send_request(REQ_SAMPLE, 10'(edge_adc - 1));
          end else begin
            send_request(REQ_SAMPLE, 10'($urandom_range(1023)));
          end
          sent++;
        end else if (roll < 82) begin
          send_request(REQ_TICK, 10'($urandom_range(1023)));
          sent++;
        end else if (roll < 94) begin
          send_request(REQ_BUTTON, 10'($urandom_range(1023)));
          sent++;
        end else begin
          send_request(REQ_UNUSED, 10'($urandom_range(1023)));
        end
      end
      settle();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_power_on_display();
    test_register_extremes();
    test_alarm_arming();
    test_random_traffic();
    $display("covered %0d scans, %0d ticks, %0d button presses, %0d unused codes",
             scans_sent, ticks_sent, presses_sent, ignored_sent);
    $display("checked %0d digit requests over four idling mixes and one long hold-off",
             digits_checked);
    if (mismatches == 0) begin
      $display("countdown_sensor_display_alarm_test: done, clean");
    end else begin
      $display("countdown_sensor_display_alarm_test: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
rtl/csda_pkg.sv
rtl/csda_front.sv
rtl/csda_queue.sv
rtl/csda_back.sv
rtl/countdown_sensor_display_alarm.sv
tb/countdown_sensor_display_alarm_test.sv
